// ===== rtl/hsec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsec_pkg
// Shared constants, result type and position helpers for the Hamming SEC
// encode/correct block.
// ----------------------------------------------------------------------------
package hsec_pkg;

  localparam int DataW       = 64;
  localparam int CfgW        = 6;
  localparam int SynW        = 6;
  localparam int MaxMsgBits  = 57;
  localparam int OutTdataW   = 80;
  localparam int ApbDataW    = 32;
  localparam int ApbAddrW    = 3;

  localparam logic [CfgW-1:0] MsgBitsReset = CfgW'(8);

  // register word index of msg_bits
  localparam logic RegMsgBits = 1'b0;

  typedef struct packed {
    logic [DataW-1:0] word;
    logic [CfgW-1:0]  code_len;
    logic [SynW-1:0]  syndrome;
    logic             error_fixed;
    logic             beyond_len;
  } hsec_res_t;

  // position p carries parity when p+1 is a power of two
  function automatic logic is_parity(input int p);
    is_parity = (((p + 1) & p) == 0);
  endfunction

  // message bit index that lands at non-parity position p
  function automatic logic [CfgW-1:0] msg_index(input int p);
    int cnt;
    cnt = 0;
    for (int j = 0; j < 7; j++) begin
      if ((1 << j) <= p) begin
        cnt = cnt + 1;
      end
    end
    msg_index = CfgW'(p - cnt);
  endfunction

  // positions covered by syndrome bit i
  function automatic logic [DataW-1:0] syn_mask(input int i);
    logic [DataW-1:0] m;
    m = '0;
    for (int p = 0; p < DataW; p++) begin
      m[p] = (((p + 1) >> i) & 1) == 1;
    end
    syn_mask = m;
  endfunction

  // least n = k + r with 2^r >= n + 1
  function automatic logic [CfgW-1:0] code_length(input logic [CfgW-1:0] k);
    logic [CfgW:0] n;
    n = {1'b0, k};
    for (int i = 0; i < 7; i++) begin
      if ((8'd1 << i) <= {1'b0, n}) begin
        n = n + 1'b1;
      end
    end
    code_length = n[CfgW-1:0];
  endfunction

endpackage

// ===== rtl/hsec_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsec_core
// Combinational Hamming SEC datapath: message scatter, shared syndrome
// XOR tree, parity insert, single-bit correction and range check.
// ----------------------------------------------------------------------------
module hsec_core import hsec_pkg::*; (
  input  logic             req_type_i,
  input  logic [DataW-1:0] data_i,
  input  logic [CfgW-1:0]  msg_bits_i,
  output hsec_res_t        res_o
);

  logic [CfgW-1:0]  k;
  logic [CfgW-1:0]  n;
  logic [DataW-1:0] msg_m;
  logic [DataW-1:0] code_m;
  logic [DataW-1:0] scat;
  logic [DataW-1:0] chk_w;
  logic [DataW-1:0] sel_w;
  logic [SynW-1:0]  syn;
  logic [DataW-1:0] enc_w;
  logic [DataW-1:0] cor_w;
  logic             syn_nz;
  logic             in_rng;

  always_comb begin
    if (msg_bits_i == '0) begin
      k = CfgW'(1);
    end else if (msg_bits_i > CfgW'(MaxMsgBits)) begin
      k = CfgW'(MaxMsgBits);
    end else begin
      k = msg_bits_i;
    end
  end

  assign n = code_length(k);

  always_comb begin
    for (int b = 0; b < DataW; b++) begin
      msg_m[b]  = data_i[b] && (7'(b) < {1'b0, k});
      code_m[b] = 7'(b) < {1'b0, n};
    end
  end

  always_comb begin
    for (int p = 0; p < DataW; p++) begin
      if (is_parity(p)) begin
        scat[p] = 1'b0;
      end else begin
        scat[p] = msg_m[msg_index(p)];
      end
    end
  end

  assign chk_w = data_i & code_m;
  assign sel_w = req_type_i ? chk_w : scat;

  always_comb begin
    for (int i = 0; i < SynW; i++) begin
      syn[i] = ^(sel_w & syn_mask(i));
    end
  end

  always_comb begin
    enc_w = scat;
    for (int i = 0; i < SynW; i++) begin
      enc_w[(1 << i) - 1] = syn[i];
    end
  end

  assign syn_nz = (syn != '0);
  assign in_rng = (syn <= n);

  always_comb begin
    for (int b = 0; b < DataW; b++) begin
      cor_w[b] = chk_w[b] ^ (syn_nz && in_rng && ({1'b0, syn} == 7'(b + 1)));
    end
  end

  always_comb begin
    res_o.code_len = n;
    if (req_type_i) begin
      res_o.word        = cor_w;
      res_o.syndrome    = syn;
      res_o.error_fixed = syn_nz && in_rng;
      res_o.beyond_len  = syn_nz && !in_rng;
    end else begin
      res_o.word        = enc_w & code_m;
      res_o.syndrome    = '0;
      res_o.error_fixed = 1'b0;
      res_o.beyond_len  = 1'b0;
    end
  end

endmodule

// ===== rtl/hamming_sec_encode_correct.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_sec_encode_correct
// Hamming SEC encoder / checker-corrector on a stream, msg_bits via APB.
// Pipeline: input reg, then result reg, from input beat to output beat.
// Throughput: 1 beat per cycle while m_axis_tready_i is high; the result register drains while input loads.
// Reset: async active low; clears both stage valids, msg_bits returns to 8.
// ----------------------------------------------------------------------------
module hamming_sec_encode_correct import hsec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB config
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ApbAddrW-1:0]  paddr,
  input  logic [ApbDataW-1:0]  pwdata,
  output logic [ApbDataW-1:0]  prdata,
  output logic                 pready,
  // input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [DataW-1:0]     s_axis_tdata_i,   // [63:0] data_in
  input  logic                 s_axis_tuser_i,   // [0] req_type
  // output stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [63:0] word_out, [69:64] code_len, [75:70] syndrome,
  // [76] error_fixed, [77] beyond_len, [79:78] zero
  output logic [OutTdataW-1:0] m_axis_tdata_o
);

  logic [CfgW-1:0]  msg_bits_q;
  logic             in_vld_q;
  logic             req_q;
  logic [DataW-1:0] data_q;
  logic             out_vld_q;
  hsec_res_t        res_d;
  hsec_res_t        res_q;
  logic             adv_out;
  logic             adv_in;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegMsgBits);
  assign prdata = (paddr[2] == RegMsgBits) ? ApbDataW'(msg_bits_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_bits_q <= MsgBitsReset;
    end else if (cfg_wr) begin
      msg_bits_q <= pwdata[CfgW-1:0];
    end
  end

  assign adv_out         = !out_vld_q || m_axis_tready_i;
  assign adv_in          = !in_vld_q || adv_out;
  assign s_axis_tready_o = adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (adv_out) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && s_axis_tvalid_i) begin
      req_q  <= s_axis_tuser_i;
      data_q <= s_axis_tdata_i;
    end
    if (adv_out && in_vld_q) begin
      res_q <= res_d;
    end
  end

  hsec_core u_core (
    .req_type_i (req_q),
    .data_i     (data_q),
    .msg_bits_i (msg_bits_q),
    .res_o      (res_d)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, res_q.beyond_len, res_q.error_fixed,
                            res_q.syndrome, res_q.code_len, res_q.word};

endmodule
